@@ rtl/cbsu_pkg.sv @@
// shared types, opcode field codes and constants for the cb prefix bit shift unit
// no dependencies; imported by cbsu_exec and cb_prefix_bit_shift_unit
`timescale 1ns / 1ps
`default_nettype none

package cbsu_pkg;

    localparam int NUM_REGS = 7;

    // register file slots (operand / load index 7 maps to slot a)
    localparam logic [2:0] SLOT_H = 3'd4;
    localparam logic [2:0] SLOT_L = 3'd5;
    localparam logic [2:0] SLOT_A = 3'd6;

    // operand code for memory at hl, load index for the flag register
    localparam logic [2:0] OPND_HL = 3'd6;
    localparam logic [2:0] IDX_F   = 3'd6;
    localparam logic [2:0] IDX_A   = 3'd7;

    // function codes
    localparam logic FUNC_EXEC = 1'b0;
    localparam logic FUNC_LOAD = 1'b1;

    // opcode block codes (bits 7:6)
    localparam logic [1:0] BLK_SHIFT = 2'd0;
    localparam logic [1:0] BLK_BIT   = 2'd1;
    localparam logic [1:0] BLK_RES   = 2'd2;
    localparam logic [1:0] BLK_SET   = 2'd3;

    // rotate / shift kinds (bits 5:3 of a shift block opcode)
    localparam logic [2:0] KIND_RLC  = 3'd0;
    localparam logic [2:0] KIND_RRC  = 3'd1;
    localparam logic [2:0] KIND_RL   = 3'd2;
    localparam logic [2:0] KIND_RR   = 3'd3;
    localparam logic [2:0] KIND_SLA  = 3'd4;
    localparam logic [2:0] KIND_SRA  = 3'd5;
    localparam logic [2:0] KIND_SWAP = 3'd6;
    localparam logic [2:0] KIND_SRL  = 3'd7;

    // flag bit positions
    localparam int FL_Z = 3;
    localparam int FL_N = 2;
    localparam int FL_H = 1;
    localparam int FL_C = 0;

    // machine clock counts reported per transaction
    localparam logic [4:0] CYC_LOAD   = 5'd0;
    localparam logic [4:0] CYC_REG    = 5'd8;
    localparam logic [4:0] CYC_BIT_HL = 5'd12;
    localparam logic [4:0] CYC_HL     = 5'd16;

    typedef logic [NUM_REGS-1:0][7:0] t_gp_regs;

    // everything one transaction produces, handed from the execute logic to the top
    typedef struct packed {
        logic [7:0] result;
        logic [3:0] flags;
        logic       mem_write;
        logic [4:0] cycles;
        logic       reg_we;
        logic [2:0] reg_slot;
    } t_exec_res;

    // operand or load index to register file slot
    function automatic logic [2:0] slot_of(input logic [2:0] idx);
        return (idx == IDX_A) ? SLOT_A : idx;
    endfunction

endpackage

`default_nettype wire

@@ rtl/cbsu_exec.sv @@
// combinational execute logic: one cb opcode or one register load per transaction
// depends on cbsu_pkg
`timescale 1ns / 1ps
`default_nettype none

module cbsu_exec (
    input  wire logic                i_func,
    input  wire logic [7:0]          i_opcode,
    input  wire logic [7:0]          i_mem_read_data,
    input  wire logic [2:0]          i_reg_index,
    input  wire logic [7:0]          i_reg_value,
    input  wire cbsu_pkg::t_gp_regs  i_regs,
    input  wire logic [3:0]          i_flags,
    output cbsu_pkg::t_exec_res      o_res
);
    import cbsu_pkg::*;

    logic [2:0] w_opnd;
    logic [2:0] w_grp;
    logic [1:0] w_blk;
    logic       w_is_hl;
    logic [7:0] w_val;
    logic [7:0] w_mask;
    logic [7:0] w_shift;
    logic       w_cout;
    logic       w_cin;

    assign w_opnd  = i_opcode[2:0];
    assign w_grp   = i_opcode[5:3];
    assign w_blk   = i_opcode[7:6];
    assign w_is_hl = (w_opnd == OPND_HL);
    assign w_val   = w_is_hl ? i_mem_read_data : i_regs[slot_of(w_opnd)];
    assign w_mask  = 8'd1 << w_grp;
    assign w_cin   = i_flags[FL_C];

    always_comb begin
        case (w_grp)
            KIND_RLC:  begin w_shift = {w_val[6:0], w_val[7]}; w_cout = w_val[7]; end
            KIND_RRC:  begin w_shift = {w_val[0], w_val[7:1]}; w_cout = w_val[0]; end
            KIND_RL:   begin w_shift = {w_val[6:0], w_cin};    w_cout = w_val[7]; end
            KIND_RR:   begin w_shift = {w_cin, w_val[7:1]};    w_cout = w_val[0]; end
            KIND_SLA:  begin w_shift = {w_val[6:0], 1'b0};     w_cout = w_val[7]; end
            KIND_SRA:  begin w_shift = {w_val[7], w_val[7:1]}; w_cout = w_val[0]; end
            KIND_SWAP: begin w_shift = {w_val[3:0], w_val[7:4]}; w_cout = 1'b0; end
            default:   begin w_shift = {1'b0, w_val[7:1]};     w_cout = w_val[0]; end
        endcase
    end

    always_comb begin
        o_res           = '0;
        o_res.flags     = i_flags;
        o_res.reg_slot  = slot_of(w_opnd);
        if (i_func == FUNC_LOAD) begin
            o_res.cycles = CYC_LOAD;
            if (i_reg_index == IDX_F) begin
                o_res.flags  = i_reg_value[7:4];
                o_res.result = {i_reg_value[7:4], 4'b0000};
            end else begin
                o_res.result   = i_reg_value;
                o_res.reg_we   = 1'b1;
                o_res.reg_slot = slot_of(i_reg_index);
            end
        end else begin
            unique case (w_blk)
                BLK_SHIFT: begin
                    o_res.result      = w_shift;
                    o_res.flags       = '0;
                    o_res.flags[FL_Z] = (w_shift == 8'd0);
                    o_res.flags[FL_C] = w_cout;
                end
                BLK_BIT: begin
                    o_res.result      = w_val;
                    o_res.flags[FL_Z] = ~|(w_val & w_mask);
                    o_res.flags[FL_N] = 1'b0;
                    o_res.flags[FL_H] = 1'b1;
                end
                BLK_RES: o_res.result = w_val & ~w_mask;
                BLK_SET: o_res.result = w_val | w_mask;
            endcase
            // bit tests write nothing back
            o_res.mem_write = w_is_hl && (w_blk != BLK_BIT);
            o_res.reg_we    = !w_is_hl && (w_blk != BLK_BIT);
            if (!w_is_hl) begin
                o_res.cycles = CYC_REG;
            end else if (w_blk == BLK_BIT) begin
                o_res.cycles = CYC_BIT_HL;
            end else begin
                o_res.cycles = CYC_HL;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/cb_prefix_bit_shift_unit.sv @@
// top level of the cb prefix bit shift unit: register file, flags, input and result registers
// depends on cbsu_pkg and cbsu_exec
//
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+-------------------------------------------------
//  request  | i_in_valid   | o_in_stall   | i_func i_opcode i_mem_read_data i_reg_index
//           |              |              | i_reg_value
//  response | o_out_valid  | i_out_stall  | o_result_value o_flags o_mem_write o_mem_addr
//           |              |              | o_cycles
//
//  one transaction per clock sustained while the response side does not stall; an accepted
//  transaction passes the input register, then the execute logic into the result register
//  the register file and flag state are written in the same edge that loads the result
//  register, so a following transaction already sees them
//  synchronous active low reset clears registers b..a, the flags and both valid bits
//  a stalled response holds; a full input register then holds too and stalls the request side
`timescale 1ns / 1ps
`default_nettype none

module cb_prefix_bit_shift_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_func,
    input  wire logic [7:0]  i_opcode,
    input  wire logic [7:0]  i_mem_read_data,
    input  wire logic [2:0]  i_reg_index,
    input  wire logic [7:0]  i_reg_value,
    // response
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_result_value,
    output logic [3:0]       o_flags,
    output logic             o_mem_write,
    output logic [15:0]      o_mem_addr,
    output logic [4:0]       o_cycles
);
    import cbsu_pkg::*;

    // input register
    logic       r_in_valid;
    logic       r_in_func;
    logic [7:0] r_in_opcode;
    logic [7:0] r_in_mem;
    logic [2:0] r_in_index;
    logic [7:0] r_in_value;

    // architectural state
    t_gp_regs   r_regs;
    t_gp_regs   n_regs;
    logic [3:0] r_flags;

    // result register
    logic        r_out_valid;
    logic [7:0]  r_out_result;
    logic [3:0]  r_out_flags;
    logic        r_out_mem_write;
    logic [15:0] r_out_addr;
    logic [4:0]  r_out_cycles;

    t_exec_res w_res;
    logic      w_adv;      // result register can take a new transaction
    logic      w_fire;     // input register moves into the result register
    logic      w_accept;   // request transaction accepted

    assign w_adv      = !r_out_valid || !i_out_stall;
    assign w_fire     = r_in_valid && w_adv;
    assign o_in_stall = r_in_valid && !w_adv;
    assign w_accept   = i_in_valid && !o_in_stall;

    cbsu_exec u_exec (
        .i_func          (r_in_func),
        .i_opcode        (r_in_opcode),
        .i_mem_read_data (r_in_mem),
        .i_reg_index     (r_in_index),
        .i_reg_value     (r_in_value),
        .i_regs          (r_regs),
        .i_flags         (r_flags),
        .o_res           (w_res)
    );

    // register file after this transaction; hl comes from it for the address
    always_comb begin
        n_regs = r_regs;
        if (w_res.reg_we) begin
            n_regs[w_res.reg_slot] = w_res.result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    // input payload, held while stalled
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_func   <= i_func;
            r_in_opcode <= i_opcode;
            r_in_mem    <= i_mem_read_data;
            r_in_index  <= i_reg_index;
            r_in_value  <= i_reg_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs  <= '0;
            r_flags <= '0;
        end else if (w_fire) begin
            r_regs  <= n_regs;
            r_flags <= w_res.flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_result    <= w_res.result;
            r_out_flags     <= w_res.flags;
            r_out_mem_write <= w_res.mem_write;
            r_out_addr      <= {n_regs[SLOT_H], n_regs[SLOT_L]};
            r_out_cycles    <= w_res.cycles;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_result;
    assign o_flags        = r_out_flags;
    assign o_mem_write    = r_out_mem_write;
    assign o_mem_addr     = r_out_addr;
    assign o_cycles       = r_out_cycles;

`ifndef SYNTHESIS
    // a memory write only comes from a read-modify-write on hl
    a_write_is_hl_rmw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_mem_write) |-> (o_cycles == CYC_HL))
        else $error("memory write without a full hl cycle count");

    // a bit test on hl never writes memory
    a_bit_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_cycles == CYC_BIT_HL)) |-> !o_mem_write)
        else $error("bit test on hl issued a memory write");

    // state only changes when a transaction executes
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !w_fire) |=> ($stable(r_regs) && $stable(r_flags)))
        else $error("register file or flags changed without a transaction");

    // an executed transaction always shows up as a response
    a_fire_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> o_out_valid)
        else $error("executed transaction lost before the result register");
`endif

endmodule

`default_nettype wire
